// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int KEY_W       = 32;
  localparam int ID_W        = 8;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int QUEUE_DEPTH = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_DEQUEUE = 3'd1,
    KIND_REMOVE  = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_UPDATE  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    STATE_IDLE,
    STATE_EXEC
  } state_t;

  // What a cell does with its slot in the execute cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_UPDATE
  } cell_op_t;

  // Which local condition marks a cell as the operation's position.
  typedef enum logic [1:0] {
    MARK_INS,
    MARK_ID,
    MARK_ALL
  } mark_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  entry_key;
    logic [ID_W-1:0]   entry_id;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ID_W-1:0]        out_id;
    logic [KEY_W-1:0]       out_key;
    logic [COUNT_OUT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    cell_op_t         op;
    mark_t            mark;
    logic             sorted;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } cell_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic                     clk,
  input  spq_pkg::cell_ctrl_t      ctrl,
  input  logic                     occ,
  input  logic [spq_pkg::KEY_W-1:0] left_key,
  input  logic [spq_pkg::ID_W-1:0]  left_id,
  input  logic [spq_pkg::KEY_W-1:0] right_key,
  input  logic [spq_pkg::ID_W-1:0]  right_id,
  input  logic                     past_in,
  output logic                     past_out,
  output logic [spq_pkg::KEY_W-1:0] key,
  output logic [spq_pkg::ID_W-1:0]  id,
  output logic [spq_pkg::KEY_W-1:0] sel_key,
  output logic [spq_pkg::ID_W-1:0]  sel_id
);

  logic mark;
  logic first;

  // An empty cell always marks for an insert, so the tail catches the new
  // entry when no held key is greater.
  always_comb begin
    case (ctrl.mark)
      spq_pkg::MARK_INS: mark = !occ || (ctrl.sorted && (key > ctrl.key));
      spq_pkg::MARK_ID:  mark = occ && (id == ctrl.id);
      spq_pkg::MARK_ALL: mark = occ;
      default:           mark = 1'b0;
    endcase
  end

  assign first    = mark && !past_in;
  assign past_out = past_in || mark;
  assign sel_key  = first ? key : '0;
  assign sel_id   = first ? id : '0;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      spq_pkg::CELL_INSERT: begin
        if (first) begin
          key <= ctrl.key;
          id  <= ctrl.id;
        end else if (past_in) begin
          key <= left_key;
          id  <= left_id;
        end
      end
      spq_pkg::CELL_REMOVE: begin
        if (past_out) begin
          key <= right_key;
          id  <= right_id;
        end
      end
      spq_pkg::CELL_UPDATE: begin
        if (first) begin
          key <= ctrl.key;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/sorted_insert_priority_queue_top.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// command   start / busy         cmd    (kind, entry_key, entry_id)
// result    done strobe          result (status, out_id, out_key, entry_count)
// config    cfg_we               cfg_data (order_mode)
//
// The command is registered at acceptance, and in the next cycle every cell
// of the row compares its slot and shifts in step. The result is shown with
// done for one cycle after that, while busy is already low again. The
// neighbor-to-neighbor mark chain sets the length of the execute cycle.
// Reset empties the queue and selects sorted order; no clearing pass runs.
// The receiver cannot stall, so done never waits.

module sorted_insert_priority_queue_top #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  spq_pkg::cmd_t    cmd,
  output logic             done,
  output spq_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::state_t     state;
  spq_pkg::state_t     state_next;
  spq_pkg::cmd_t       cmd_q;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::result_t    result_next;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                order_mode;
  logic                is_full;
  logic                found;
  logic [spq_pkg::KEY_W-1:0] found_key;
  logic [spq_pkg::ID_W-1:0]  found_id;

  logic [spq_pkg::KEY_W-1:0] cell_key [QUEUE_DEPTH];
  logic [spq_pkg::ID_W-1:0]  cell_id  [QUEUE_DEPTH];
  logic [spq_pkg::KEY_W-1:0] sel_key  [QUEUE_DEPTH];
  logic [spq_pkg::ID_W-1:0]  sel_id   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]      past;

  assign busy    = (state == spq_pkg::STATE_EXEC);
  assign is_full = (count == CNT_W'(QUEUE_DEPTH));
  assign past[0] = 1'b0;
  assign found   = past[QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spq_pkg::STATE_IDLE;
      count      <= '0;
      order_mode <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == spq_pkg::STATE_EXEC);
      if (cfg_we) begin
        order_mode <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
    if (state == spq_pkg::STATE_EXEC) begin
      result <= result_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::STATE_IDLE: if (start) state_next = spq_pkg::STATE_EXEC;
      spq_pkg::STATE_EXEC: state_next = spq_pkg::STATE_IDLE;
      default:             state_next = spq_pkg::STATE_IDLE;
    endcase
  end

  // Cell control depends only on the command, the state, the count and the order
  // mode, never on the search outcome; a remove or update with no match touches no cell.
  always_comb begin
    ctrl.op     = spq_pkg::CELL_HOLD;
    ctrl.mark   = spq_pkg::MARK_ID;
    ctrl.sorted = !order_mode;
    ctrl.key    = cmd_q.entry_key;
    ctrl.id     = cmd_q.entry_id;
    case (cmd_q.kind)
      spq_pkg::KIND_INSERT: begin
        ctrl.mark = spq_pkg::MARK_INS;
        if (busy && !is_full) ctrl.op = spq_pkg::CELL_INSERT;
      end
      spq_pkg::KIND_DEQUEUE: begin
        ctrl.mark = spq_pkg::MARK_ALL;
        if (busy) ctrl.op = spq_pkg::CELL_REMOVE;
      end
      spq_pkg::KIND_REMOVE: begin
        if (busy) ctrl.op = spq_pkg::CELL_REMOVE;
      end
      spq_pkg::KIND_UPDATE: begin
        if (busy) ctrl.op = spq_pkg::CELL_UPDATE;
      end
      default: ;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic [spq_pkg::KEY_W-1:0] lk;
      logic [spq_pkg::ID_W-1:0]  li;
      logic [spq_pkg::KEY_W-1:0] rk;
      logic [spq_pkg::ID_W-1:0]  ri;
      if (gi == 0) begin : g_left_end
        assign lk = '0;
        assign li = '0;
      end else begin : g_left
        assign lk = cell_key[gi-1];
        assign li = cell_id[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_right_end
        assign rk = '0;
        assign ri = '0;
      end else begin : g_right
        assign rk = cell_key[gi+1];
        assign ri = cell_id[gi+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (CNT_W'(gi) < count),
        .left_key  (lk),
        .left_id   (li),
        .right_key (rk),
        .right_id  (ri),
        .past_in   (past[gi]),
        .past_out  (past[gi+1]),
        .key       (cell_key[gi]),
        .id        (cell_id[gi]),
        .sel_key   (sel_key[gi]),
        .sel_id    (sel_id[gi])
      );
    end
  endgenerate

  // At most one cell is first, so an OR over the row picks its entry.
  always_comb begin
    found_key = '0;
    found_id  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      found_key = found_key | sel_key[i];
      found_id  = found_id | sel_id[i];
    end
  end

  always_comb begin
    result_next        = '0;
    result_next.status = spq_pkg::STAT_OK;
    count_next         = count;
    case (cmd_q.kind)
      spq_pkg::KIND_INSERT: begin
        if (is_full) begin
          result_next.status = spq_pkg::STAT_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      spq_pkg::KIND_DEQUEUE: begin
        if (count == '0) begin
          result_next.status = spq_pkg::STAT_EMPTY;
        end else begin
          result_next.out_id  = found_id;
          result_next.out_key = found_key;
          count_next          = count - 1'b1;
        end
      end
      spq_pkg::KIND_REMOVE, spq_pkg::KIND_QUERY, spq_pkg::KIND_UPDATE: begin
        if (!found) begin
          result_next.status = spq_pkg::STAT_NOTFOUND;
        end else begin
          result_next.out_id  = found_id;
          result_next.out_key = (cmd_q.kind == spq_pkg::KIND_UPDATE) ?
                                cmd_q.entry_key : found_key;
          if (cmd_q.kind == spq_pkg::KIND_REMOVE) begin
            count_next = count - 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (state != spq_pkg::STATE_EXEC) begin
      count_next = count;
    end
    result_next.entry_count = spq_pkg::COUNT_OUT_W'(count_next);
  end

endmodule

// File: rtl/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input spq_pkg::result_t result
);

  // An accepted item keeps the block busy for exactly one cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted item did not enter execution");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("execution did not produce a result in the next cycle");

  // A refused insert only happens with the queue holding its full depth.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == spq_pkg::STAT_FULL) |->
    result.entry_count == spq_pkg::COUNT_OUT_W'(QUEUE_DEPTH))
    else $error("full status with a count below the depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != spq_pkg::STAT_OK) |->
    (result.out_id == '0) && (result.out_key == '0))
    else $error("failed operation returned entry data");

endmodule

bind sorted_insert_priority_queue_top spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .result   (result)
);
